@@ hw/rtl/stv_pkg.sv @@
// Package for the slope to Vs30 converter: fixed log tables, root table,
// shared widths, register indexes and the pipeline sideband type.
// Depends on nothing; the tables are built at elaboration by constant functions.
package stv_pkg;

   localparam int POP_ROWS   = 6;
   localparam int ROW_W      = 3;
   localparam int LOG_W      = 24;
   localparam int E_W        = LOG_W + 1;
   localparam int ONE_Q16    = 65536;
   localparam int ROOT_STEPS = 16;

   localparam logic [31:0] VMIN_SCALED = 32'd737280;
   localparam logic [31:0] VMAX_SCALED = 32'd3686400;

   localparam logic signed [LOG_W-1:0] L_OFFSET = LOG_W'(24 * ONE_Q16);
   localparam logic signed [E_W-1:0]   E_LOW    = E_W'(-12 * ONE_Q16);
   localparam logic signed [E_W-1:0]   E_HIGH   = E_W'(20 * ONE_Q16);
   localparam logic signed [E_W-1:0]   E_BIAS   = E_W'(12 * ONE_Q16);

   localparam logic [1:0] CSR_WATER_VELOCITY    = 2'd0;
   localparam logic [1:0] CSR_WEIGHT_FROM_INPUT = 2'd1;
   localparam logic [1:0] CSR_FIXED_WEIGHT      = 2'd2;

   typedef logic [31:0]             raw_row_type  [0:POP_ROWS];
   typedef logic signed [LOG_W-1:0] log_row_type  [0:POP_ROWS];
   typedef log_row_type             log_tab_type  [0:1];
   typedef logic [31:0]             root_tab_type [1:ROOT_STEPS];

   typedef enum logic [1:0] {
      SEG_MID,
      SEG_FLOOR,
      SEG_CAP
   } seg_mode_type;

   typedef struct packed {
      logic         land;
      logic         zero;
      logic [16:0]  weight;
      logic [15:0]  water;
      seg_mode_type mode_c;
      seg_mode_type mode_a;
   } sideband_type;

   localparam raw_row_type VEL_RAW = '{32'd180, 32'd240, 32'd300, 32'd360,
                                       32'd490, 32'd620, 32'd760};
   localparam raw_row_type SLOPE_RAW_CRATON = '{32'd336, 32'd33554, 32'd67109,
      32'd120796, 32'd218104, 32'd301990, 32'd419430};
   localparam raw_row_type SLOPE_RAW_ACTIVE = '{32'd5033, 32'd58720, 32'd167772,
      32'd301990, 32'd838861, 32'd1677722, 32'd2348810};

   // Same squaring method as the runtime pipeline, evaluated at elaboration.
   function automatic logic signed [LOG_W-1:0] lg2_q16(input logic [31:0] x);
      logic [63:0] m;
      logic [4:0]  p;
      logic [15:0] frac;
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) p = 5'(i);
      end
      m = 64'(x) << (5'd31 - p);
      frac = '0;
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m[32]) begin
            m = m >> 1;
            frac[i] = 1'b1;
         end
      end
      return $signed(LOG_W'({p, frac}));
   endfunction

   function automatic log_row_type raw_logs(input raw_row_type raw,
                                           input logic signed [LOG_W-1:0] offset);
      log_row_type res;
      for (int i = 0; i <= POP_ROWS; i++) begin
         res[i] = lg2_q16(raw[i]) - offset;
      end
      return res;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bit_v;
      x = x_in;
      res = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > x) bit_v = bit_v >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != 64'd0) begin
            if (x >= res + bit_v) begin
               x = x - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   function automatic root_tab_type make_roots();
      root_tab_type res;
      logic [63:0]  r;
      r = 64'd1 << 31;
      for (int k = 1; k <= ROOT_STEPS; k++) begin
         r = isqrt64(r << 30);
         res[k] = r[31:0];
      end
      return res;
   endfunction

   localparam log_row_type  VEL_LOG   = raw_logs(VEL_RAW, '0);
   localparam log_tab_type  SLOPE_LOG = '{raw_logs(SLOPE_RAW_CRATON, L_OFFSET),
                                          raw_logs(SLOPE_RAW_ACTIVE, L_OFFSET)};
   localparam root_tab_type ROOT      = make_roots();

endpackage

@@ hw/rtl/slope_to_vs30_converter_core.sv @@
// Slope to Vs30 converter core, built on stv_pkg for its tables and types. It takes one grid
// cell per clock: a transaction is accepted whenever start is high and busy is low, and busy
// is only high during reset. The datapath is a fixed pipeline (a squaring log unit, segment
// lookup, a restoring divider one quotient bit per stage, a root-product exponent unit and the
// blend), so every cell yields exactly one result, in order. The result is strobed on
// rsp_valid for one cycle. The pipeline depth is set by 16 log squaring stages, 22 divider
// stages and 16 exponent stages plus the input, lookup, operand, product and blend registers.
// The receiver cannot stall it and results must be taken as they appear. Water cells pass
// the same pipeline and return water_velocity.
// Configuration writes take effect at once and should only be made while no cell is in flight.
module slope_to_vs30_converter_core #(
   parameter int TABLE_ROWS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_slope,
   input  logic        req_is_land,
   input  logic [16:0] req_craton_weight,
   output logic        rsp_valid,
   output logic [15:0] rsp_vs30,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_write_data
);

   localparam int ROWS_USED = (TABLE_ROWS < 2) ? 2 :
                              ((TABLE_ROWS > stv_pkg::POP_ROWS) ? stv_pkg::POP_ROWS : TABLE_ROWS);
   localparam int LAST_ROW  = ROWS_USED - 1;
   localparam int LOG_W     = stv_pkg::LOG_W;
   localparam int E_W       = stv_pkg::E_W;
   localparam int ROW_W     = stv_pkg::ROW_W;
   localparam int LG_STEPS  = 16;
   localparam int PW_STEPS  = stv_pkg::ROOT_STEPS;
   localparam int DIV_BITS  = 22;
   localparam int PROD_W    = 2 * LOG_W + 1;
   localparam int MAG_W     = PROD_W - 1;
   localparam int QS_W      = DIV_BITS + 1;

   localparam int ST_IN    = 0;
   localparam int ST_NORM  = ST_IN + 1;
   localparam int ST_LOG   = ST_NORM + LG_STEPS + 1;
   localparam int ST_SEG   = ST_LOG + 1;
   localparam int ST_OPS   = ST_SEG + 1;
   localparam int ST_MUL   = ST_OPS + 1;
   localparam int ST_MAG   = ST_MUL + 1;
   localparam int ST_QS    = ST_MAG + DIV_BITS + 1;
   localparam int ST_LV    = ST_QS + 1;
   localparam int ST_PREP  = ST_LV + 1;
   localparam int ST_VEL   = ST_PREP + PW_STEPS + 1;
   localparam int ST_CLAMP = ST_VEL + 1;
   localparam int ST_PROD  = ST_CLAMP + 1;
   localparam int ST_OUT   = ST_PROD + 1;

   localparam logic [15:0] FLOOR_VS30 = 16'd2880;

   // Configuration registers.
   logic [15:0] water_ff;
   logic        wsel_ff;
   logic [16:0] fixed_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         water_ff   <= 16'd9600;
         wsel_ff    <= 1'b0;
         fixed_w_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            stv_pkg::CSR_WATER_VELOCITY:    water_ff   <= csr_write_data[15:0];
            stv_pkg::CSR_WEIGHT_FROM_INPUT: wsel_ff    <= csr_write_data[0];
            stv_pkg::CSR_FIXED_WEIGHT:      fixed_w_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic accept;
   assign busy   = reset;
   assign accept = start & ~busy;

   // Valid bits and sideband travel with the data.
   logic                  valid_ff [0:ST_OUT];
   stv_pkg::sideband_type sb_ff    [0:ST_PROD];
   stv_pkg::sideband_type sb_in;
   stv_pkg::sideband_type sb_seg;
   stv_pkg::seg_mode_type seg_mode [0:1];
   logic [16:0]           w_sel;

   always_comb begin
      w_sel = wsel_ff ? req_craton_weight : fixed_w_ff;
      sb_in.land   = req_is_land;
      sb_in.zero   = (req_slope == 32'd0);
      sb_in.weight = (w_sel > 17'd65536) ? 17'd65536 : w_sel;
      sb_in.water  = water_ff;
      sb_in.mode_c = stv_pkg::SEG_MID;
      sb_in.mode_a = stv_pkg::SEG_MID;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= ST_OUT; i++) valid_ff[i] <= 1'b0;
      end else begin
         valid_ff[ST_IN] <= accept;
         for (int i = 1; i <= ST_OUT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      sb_ff[ST_IN] <= sb_in;
      for (int i = 1; i <= ST_PROD; i++) begin
         if (i == ST_SEG) begin
            sb_ff[i] <= sb_seg;
         end else begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   // Base-2 log of the slope: normalize, then one squaring per fraction bit.
   logic [31:0] slope_ff;
   logic [4:0]  norm_p;
   logic [31:0] norm_m;
   logic [31:0] lg_m_ff    [0:LG_STEPS];
   logic [4:0]  lg_p_ff    [0:LG_STEPS];
   logic [15:0] lg_frac_ff [0:LG_STEPS];
   logic [32:0] lg_t       [0:LG_STEPS-1];

   always_comb begin
      norm_p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (slope_ff[i]) norm_p = 5'(i);
      end
      norm_m = slope_ff << (5'd31 - norm_p);
      for (int j = 0; j < LG_STEPS; j++) begin
         lg_t[j] = 33'((64'(lg_m_ff[j]) * 64'(lg_m_ff[j])) >> 31);
      end
   end

   always_ff @(posedge clock) begin
      slope_ff      <= req_slope;
      lg_m_ff[0]    <= norm_m;
      lg_p_ff[0]    <= norm_p;
      lg_frac_ff[0] <= '0;
      for (int j = 0; j < LG_STEPS; j++) begin
         lg_m_ff[j+1]    <= lg_t[j][32] ? lg_t[j][32:1] : lg_t[j][31:0];
         lg_p_ff[j+1]    <= lg_p_ff[j];
         lg_frac_ff[j+1] <= lg_frac_ff[j] | (16'(lg_t[j][32]) << (15 - j));
      end
   end

   logic signed [LOG_W-1:0] log_l_ff;
   always_ff @(posedge clock) begin
      log_l_ff <= $signed({3'b000, lg_p_ff[LG_STEPS], lg_frac_ff[LG_STEPS]}) - stv_pkg::L_OFFSET;
   end

   // Segment choice for both tables.
   logic [ROW_W-1:0]        seg_row;
   logic [ROW_W-1:0]        seg_row_c [0:1];
   logic [ROW_W-1:0]        seg_row_ff [0:1];
   logic signed [LOG_W-1:0] seg_l_ff;

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         seg_row = ROW_W'(LAST_ROW);
         for (int r = LAST_ROW - 1; r >= 0; r--) begin
            if (log_l_ff <= stv_pkg::SLOPE_LOG[t][r+1]) seg_row = ROW_W'(r);
         end
         priority if (log_l_ff <= stv_pkg::SLOPE_LOG[t][0]) begin
            seg_row_c[t] = '0;
            seg_mode[t]  = stv_pkg::SEG_FLOOR;
         end else if (log_l_ff >= stv_pkg::SLOPE_LOG[t][LAST_ROW+1]) begin
            seg_row_c[t] = ROW_W'(LAST_ROW);
            seg_mode[t]  = stv_pkg::SEG_CAP;
         end else begin
            seg_row_c[t] = seg_row;
            seg_mode[t]  = stv_pkg::SEG_MID;
         end
      end
      sb_seg        = sb_ff[ST_SEG-1];
      sb_seg.mode_c = seg_mode[0];
      sb_seg.mode_a = seg_mode[1];
   end

   always_ff @(posedge clock) begin
      seg_l_ff <= log_l_ff;
      for (int t = 0; t < 2; t++) seg_row_ff[t] <= seg_row_c[t];
   end

   // Segment operands, product, sign and magnitude.
   logic [ROW_W-1:0]         ops_nxt   [0:1];
   logic signed [LOG_W-1:0]  ops_v0_ff [0:1];
   logic signed [LOG_W-1:0]  ops_dv_ff [0:1];
   logic signed [LOG_W:0]    ops_diff_ff [0:1];
   logic [LOG_W-1:0]         ops_den_ff [0:1];
   logic signed [PROD_W-1:0] mul_p_ff  [0:1];
   logic signed [LOG_W-1:0]  mul_v0_ff [0:1];
   logic [LOG_W-1:0]         mul_den_ff [0:1];

   always_comb begin
      for (int t = 0; t < 2; t++) ops_nxt[t] = ROW_W'(seg_row_ff[t] + 1'b1);
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < 2; t++) begin
         ops_v0_ff[t]   <= stv_pkg::VEL_LOG[seg_row_ff[t]];
         ops_dv_ff[t]   <= stv_pkg::VEL_LOG[ops_nxt[t]] - stv_pkg::VEL_LOG[seg_row_ff[t]];
         ops_diff_ff[t] <= (LOG_W+1)'(seg_l_ff)
                           - (LOG_W+1)'(stv_pkg::SLOPE_LOG[t][seg_row_ff[t]]);
         ops_den_ff[t]  <= LOG_W'(stv_pkg::SLOPE_LOG[t][ops_nxt[t]]
                           - stv_pkg::SLOPE_LOG[t][seg_row_ff[t]]);
         mul_p_ff[t]    <= PROD_W'(ops_dv_ff[t]) * PROD_W'(ops_diff_ff[t]);
         mul_v0_ff[t]   <= ops_v0_ff[t];
         mul_den_ff[t]  <= ops_den_ff[t];
      end
   end

   // Restoring divider, one quotient bit per stage, truncating toward zero.
   logic [MAG_W-1:0]        div_rem_ff [0:1][0:DIV_BITS];
   logic [DIV_BITS-1:0]     div_q_ff   [0:1][0:DIV_BITS];
   logic                    div_neg_ff [0:1][0:DIV_BITS];
   logic [LOG_W-1:0]        div_den_ff [0:1][0:DIV_BITS];
   logic signed [LOG_W-1:0] div_v0_ff  [0:1][0:DIV_BITS];
   logic [MAG_W-1:0]        div_sh     [0:1][0:DIV_BITS-1];

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         for (int k = 0; k < DIV_BITS; k++) begin
            div_sh[t][k] = MAG_W'(div_den_ff[t][k]) << (DIV_BITS - 1 - k);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < 2; t++) begin
         div_rem_ff[t][0] <= mul_p_ff[t][PROD_W-1] ? MAG_W'(-mul_p_ff[t]) : MAG_W'(mul_p_ff[t]);
         div_q_ff[t][0]   <= '0;
         div_neg_ff[t][0] <= mul_p_ff[t][PROD_W-1];
         div_den_ff[t][0] <= mul_den_ff[t];
         div_v0_ff[t][0]  <= mul_v0_ff[t];
         for (int k = 0; k < DIV_BITS; k++) begin
            if (div_rem_ff[t][k] >= div_sh[t][k]) begin
               div_rem_ff[t][k+1] <= div_rem_ff[t][k] - div_sh[t][k];
               div_q_ff[t][k+1]   <= div_q_ff[t][k] | (DIV_BITS'(1) << (DIV_BITS - 1 - k));
            end else begin
               div_rem_ff[t][k+1] <= div_rem_ff[t][k];
               div_q_ff[t][k+1]   <= div_q_ff[t][k];
            end
            div_neg_ff[t][k+1] <= div_neg_ff[t][k];
            div_den_ff[t][k+1] <= div_den_ff[t][k];
            div_v0_ff[t][k+1]  <= div_v0_ff[t][k];
         end
      end
   end

   logic signed [QS_W-1:0]  qs_q_ff  [0:1];
   logic signed [LOG_W-1:0] qs_v0_ff [0:1];
   logic signed [E_W-1:0]   lv_e_ff  [0:1];

   always_ff @(posedge clock) begin
      for (int t = 0; t < 2; t++) begin
         qs_q_ff[t]  <= div_neg_ff[t][DIV_BITS] ? -$signed({1'b0, div_q_ff[t][DIV_BITS]})
                                                :  $signed({1'b0, div_q_ff[t][DIV_BITS]});
         qs_v0_ff[t] <= div_v0_ff[t][DIV_BITS];
         lv_e_ff[t]  <= E_W'(qs_v0_ff[t]) + E_W'(qs_q_ff[t]);
      end
   end

   // Exponent: the fraction bits select square roots of two to multiply in.
   logic signed [E_W-1:0] pw_u      [0:1];
   logic [31:0]           pw_m_ff   [0:1][0:PW_STEPS];
   logic [4:0]            pw_ip_ff  [0:1][0:PW_STEPS];
   logic [15:0]           pw_f_ff   [0:1][0:PW_STEPS];
   logic                  pw_unf_ff [0:1][0:PW_STEPS];
   logic                  pw_ovf_ff [0:1][0:PW_STEPS];
   logic [31:0]           pw_prod   [0:1][1:PW_STEPS];

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         pw_u[t] = lv_e_ff[t] + stv_pkg::E_BIAS;
         for (int k = 1; k <= PW_STEPS; k++) begin
            pw_prod[t][k] = 32'((64'(pw_m_ff[t][k-1]) * 64'(stv_pkg::ROOT[k])) >> 30);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < 2; t++) begin
         pw_m_ff[t][0]   <= 32'h4000_0000;
         pw_ip_ff[t][0]  <= pw_u[t][20:16];
         pw_f_ff[t][0]   <= pw_u[t][15:0];
         pw_unf_ff[t][0] <= (lv_e_ff[t] < stv_pkg::E_LOW);
         pw_ovf_ff[t][0] <= (lv_e_ff[t] >= stv_pkg::E_HIGH);
         for (int k = 1; k <= PW_STEPS; k++) begin
            pw_m_ff[t][k]   <= pw_f_ff[t][k-1][PW_STEPS-k] ? pw_prod[t][k] : pw_m_ff[t][k-1];
            pw_ip_ff[t][k]  <= pw_ip_ff[t][k-1];
            pw_f_ff[t][k]   <= pw_f_ff[t][k-1];
            pw_unf_ff[t][k] <= pw_unf_ff[t][k-1];
            pw_ovf_ff[t][k] <= pw_ovf_ff[t][k-1];
         end
      end
   end

   logic [63:0] vel_full [0:1];
   logic [33:0] vel_r    [0:1];
   logic [31:0] vel_v_ff [0:1];

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         vel_full[t] = (64'(pw_m_ff[t][PW_STEPS]) << pw_ip_ff[t][PW_STEPS]) + (64'd1 << 29);
         vel_r[t]    = vel_full[t][63:30];
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < 2; t++) begin
         priority if (pw_unf_ff[t][PW_STEPS]) begin
            vel_v_ff[t] <= '0;
         end else if (pw_ovf_ff[t][PW_STEPS] || (vel_r[t][33:32] != 2'b00)) begin
            vel_v_ff[t] <= 32'hFFFF_FFFF;
         end else begin
            vel_v_ff[t] <= vel_r[t][31:0];
         end
      end
   end

   // Floor below the first row, cap above the last, and the zero-slope case.
   stv_pkg::seg_mode_type clamp_mode [0:1];
   logic [31:0]           clamp_c    [0:1];
   logic [31:0]           clamp_v_ff [0:1];

   always_comb begin
      clamp_mode[0] = sb_ff[ST_VEL].mode_c;
      clamp_mode[1] = sb_ff[ST_VEL].mode_a;
      for (int t = 0; t < 2; t++) begin
         unique case (clamp_mode[t])
            stv_pkg::SEG_FLOOR: clamp_c[t] = (vel_v_ff[t] < stv_pkg::VMIN_SCALED)
                                             ? stv_pkg::VMIN_SCALED : vel_v_ff[t];
            stv_pkg::SEG_CAP:   clamp_c[t] = (vel_v_ff[t] > stv_pkg::VMAX_SCALED)
                                             ? stv_pkg::VMAX_SCALED : vel_v_ff[t];
            default:            clamp_c[t] = vel_v_ff[t];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < 2; t++) begin
         clamp_v_ff[t] <= sb_ff[ST_VEL].zero ? stv_pkg::VMIN_SCALED : clamp_c[t];
      end
   end

   // Blend by the craton weight, round to 1/16 m/s and saturate; water cells return water_velocity.
   logic [48:0] prod_c_ff;
   logic [48:0] prod_a_ff;
   logic [49:0] blend_sum;
   logic [25:0] blend_q;
   logic [15:0] out_ff;

   always_comb begin
      blend_sum = 50'(prod_c_ff) + 50'(prod_a_ff) + (50'd1 << 23);
      blend_q   = blend_sum[49:24];
   end

   always_ff @(posedge clock) begin
      prod_c_ff <= 49'(sb_ff[ST_CLAMP].weight) * 49'(clamp_v_ff[0]);
      prod_a_ff <= 49'(17'd65536 - sb_ff[ST_CLAMP].weight) * 49'(clamp_v_ff[1]);
      if (!sb_ff[ST_PROD].land) begin
         out_ff <= sb_ff[ST_PROD].water;
      end else if (blend_q > 26'd65535) begin
         out_ff <= 16'hFFFF;
      end else begin
         out_ff <= blend_q[15:0];
      end
   end

   assign rsp_valid = valid_ff[ST_OUT];
   assign rsp_vs30  = out_ff;

   // Every accepted transaction produces its result strobe at the pipeline output.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(ST_OUT + 1) rsp_valid)
      else $error("result strobe missing after accepted transaction");

   // A land cell with zero slope must come out at the velocity floor.
   a_zero_slope: assert property (@(posedge clock) disable iff (reset)
      (accept && req_is_land && (req_slope == 32'd0)) |-> ##(ST_OUT + 1)
      (rsp_vs30 == FLOOR_VS30))
      else $error("zero slope land cell not at velocity floor");

   // The quotient must fit the divider: the final remainder is below the divisor.
   a_div_fit: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_MAG + DIV_BITS] |->
      ((div_rem_ff[0][DIV_BITS] < MAG_W'(div_den_ff[0][DIV_BITS])) &&
       (div_rem_ff[1][DIV_BITS] < MAG_W'(div_den_ff[1][DIV_BITS]))))
      else $error("divider remainder not below divisor");

endmodule

@@ tb/slope_to_vs30_converter_core_test.sv @@
// Self-checking testbench for slope_to_vs30_converter_core: a directed table of grid cells,
// then random cells under several register settings, all checked against a local predictor.
// Depends on stv_pkg for the register indexes and on the core itself.
`timescale 1ns / 100ps

module slope_to_vs30_converter_core_test;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int CRATON = 0;
   localparam int ACTIVE = 1;
   localparam int LAST_ROW = 5;
   localparam longint Q16 = 65536;
   localparam longint V_FLOOR = 180 * 4096;
   localparam longint V_CAP = 900 * 4096;
   localparam int DRAIN_CYCLES = 80;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_slope;
   logic        req_is_land;
   logic [16:0] req_craton_weight;
   logic        rsp_valid;
   logic [15:0] rsp_vs30;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [16:0] csr_write_data;

   slope_to_vs30_converter_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_slope(req_slope), .req_is_land(req_is_land),
      .req_craton_weight(req_craton_weight),
      .rsp_valid(rsp_valid), .rsp_vs30(rsp_vs30),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   typedef struct {
      logic [31:0] slope;
      logic        land;
      logic [16:0] weight;
      bit          known;
      logic [15:0] vs30;
   } cell_row_type;

   // Register copies held by the predictor.
   logic [15:0] water_reg;
   logic        weight_sel_reg;
   logic [16:0] fixed_weight_reg;

   longint unsigned root_q30 [0:16];
   longint vel_log [0:6];
   longint slope_log [0:1][0:6];
   int unsigned vel_pts [0:6] = '{180, 240, 300, 360, 490, 620, 760};
   int unsigned slope_pts [0:1][0:6] = '{
      '{336, 33554, 67109, 120796, 218104, 301990, 419430},
      '{5033, 58720, 167772, 301990, 838861, 1677722, 2348810}};

   logic [15:0] vs30_expected [$];
   int errors = 0;
   int accepted = 0;
   int land_cells = 0;
   int results_seen = 0;
   int settings_used = 1;

   // Log2 in Q16.16 by repeated squaring of a Q1.31 mantissa.
   function automatic longint log2_q16(logic [31:0] x);
      longint unsigned m;
      int p;
      logic [15:0] frac;
      if (x == 0) return 0;
      p = 31;
      while (!x[p]) p--;
      m = longint'(x) << (31 - p);
      frac = '0;
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac[i] = 1'b1;
         end
      end
      return longint'(p) * Q16 + longint'(frac);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned cand;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         if (cand * cand <= x) res = cand;
      end
      return res;
   endfunction

   // 2^e for e in Q16.16, in units of 2^-12, saturated to 32 bits.
   function automatic longint exp2_scaled(longint e);
      longint unsigned m;
      longint unsigned v;
      longint u;
      int ip;
      if (e < -12 * Q16) return 0;
      if (e >= 20 * Q16) return 64'hFFFF_FFFF;
      u = e + 12 * Q16;
      ip = int'(u >> 16);
      m = 64'd1 << 30;
      for (int k = 1; k <= 16; k++) begin
         if (u[16 - k]) m = (m * root_q30[k]) >> 30;
      end
      v = ((m << ip) + (64'd1 << 29)) >> 30;
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      return longint'(v);
   endfunction

   function automatic longint segment_log(int t, int r, longint lg);
      longint v0, v1, s0, s1;
      v0 = vel_log[r];
      v1 = vel_log[r + 1];
      s0 = slope_log[t][r];
      s1 = slope_log[t][r + 1];
      if (s1 <= s0) return v0;
      return v0 + ((v1 - v0) * (lg - s0)) / (s1 - s0);
   endfunction

   function automatic longint region_velocity(int t, longint lg);
      longint v;
      int r;
      if (lg <= slope_log[t][0]) begin
         v = exp2_scaled(segment_log(t, 0, lg));
         return (v < V_FLOOR) ? V_FLOOR : v;
      end
      if (lg >= slope_log[t][LAST_ROW + 1]) begin
         v = exp2_scaled(segment_log(t, LAST_ROW, lg));
         return (v > V_CAP) ? V_CAP : v;
      end
      r = 0;
      while (r < LAST_ROW && lg > slope_log[t][r + 1]) r++;
      return exp2_scaled(segment_log(t, r, lg));
   endfunction

   function automatic logic [15:0] cell_vs30(logic [31:0] slope, logic land,
                                             logic [16:0] cell_weight);
      longint w, vc, va, lg, sum;
      if (!land) return water_reg;
      w = weight_sel_reg ? longint'(cell_weight) : longint'(fixed_weight_reg);
      if (w > Q16) w = Q16;
      if (slope == 0) begin
         vc = V_FLOOR;
         va = V_FLOOR;
      end else begin
         lg = log2_q16(slope) - 24 * Q16;
         vc = region_velocity(CRATON, lg);
         va = region_velocity(ACTIVE, lg);
      end
      sum = (w * vc + (Q16 - w) * va + (64'd1 << 23)) >> 24;
      if (sum > 65535) sum = 65535;
      return sum[15:0];
   endfunction

   initial begin
      root_q30[0] = 64'd1 << 31;
      for (int k = 1; k <= 16; k++) root_q30[k] = floor_sqrt(root_q30[k - 1] << 30);
      for (int i = 0; i <= 6; i++) begin
         vel_log[i] = log2_q16(vel_pts[i]);
         for (int t = 0; t < 2; t++) slope_log[t][i] = log2_q16(slope_pts[t][i]) - 24 * Q16;
      end
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Accepts transactions, mirrors register writes and checks results.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            results_seen++;
            if (vs30_expected.size() == 0) begin
               $error("vs30: result %0h with no transaction outstanding", rsp_vs30);
               errors++;
            end else if (rsp_vs30 !== vs30_expected[0]) begin
               $error("vs30: expected %0d, actual %0d", vs30_expected[0], rsp_vs30);
               errors++;
               void'(vs30_expected.pop_front());
            end else begin
               void'(vs30_expected.pop_front());
            end
         end
         if (start && !busy) begin
            vs30_expected.push_back(cell_vs30(req_slope, req_is_land, req_craton_weight));
            if (req_is_land) land_cells++;
            accepted++;
         end
         if (csr_write_enable) begin
            case (csr_index)
               stv_pkg::CSR_WATER_VELOCITY: water_reg = csr_write_data[15:0];
               stv_pkg::CSR_WEIGHT_FROM_INPUT: weight_sel_reg = csr_write_data[0];
               stv_pkg::CSR_FIXED_WEIGHT: fixed_weight_reg = csr_write_data;
               default: ;
            endcase
         end
      end
   end

   task automatic send_cell(logic [31:0] slope, logic land, logic [16:0] cell_weight,
                            int gap);
      int target;
      start <= 1'b1;
      req_slope <= slope;
      req_is_land <= land;
      req_craton_weight <= cell_weight;
      target = accepted + 1;
      wait (accepted == target);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Ends the stream of cells and waits for every outstanding result.
   task automatic drain();
      start <= 1'b0;
      wait (vs30_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(logic [16:0] water, logic [16:0] sel, logic [16:0] fixed_w);
      csr_write_enable <= 1'b1;
      csr_index <= stv_pkg::CSR_WATER_VELOCITY;
      csr_write_data <= water;
      @(posedge clock);
      csr_index <= stv_pkg::CSR_WEIGHT_FROM_INPUT;
      csr_write_data <= sel;
      @(posedge clock);
      csr_index <= stv_pkg::CSR_FIXED_WEIGHT;
      csr_write_data <= fixed_w;
      @(posedge clock);
      // The unused index must leave every register alone.
      csr_index <= CSR_UNUSED;
      csr_write_data <= 17'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   function automatic int random_gap(bit busy_phase);
      int roll;
      roll = $urandom_range(99);
      if (busy_phase || roll < 65) return 0;
      if (roll < 94) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [31:0] random_slope();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return $urandom_range(3000000, 200);
      if (roll < 60) return 32'($urandom_range(200, 1)) << $urandom_range(31, 0);
      if (roll < 68) return '0;
      if (roll < 72) return slope_pts[$urandom_range(1)][$urandom_range(6)]
                            + $urandom_range(2) - 1;
      return $urandom;
   endfunction

   function automatic logic [16:0] random_weight();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15) return 17'd0;
      if (roll < 30) return 17'd65536;
      if (roll < 70) return 17'($urandom_range(65536));
      return 17'($urandom);
   endfunction

   task automatic random_cells(int count, bit busy_phase);
      for (int i = 0; i < count; i++) begin
         send_cell(random_slope(), $urandom_range(99) < 85, random_weight(),
                   random_gap(busy_phase));
         // Outside the busy phase, hold off once mid-phase until the pipeline is empty.
         if (i == count / 2 && !busy_phase) begin
            start <= 1'b0;
            wait (vs30_expected.size() == 0);
            @(posedge clock);
         end
      end
      drain();
   endtask

   cell_row_type directed [0:19] = '{
      '{32'd0,          1'b0, 17'd0, 1'b1, 16'd9600},
      '{32'hFFFF_FFFF,  1'b0, 17'h1FFFF, 1'b1, 16'd9600},
      '{32'd0,          1'b1, 17'd0, 1'b1, 16'd2880},
      '{32'd1,          1'b1, 17'd0, 1'b1, 16'd2880},
      '{32'hFFFF_FFFF,  1'b1, 17'h1FFFF, 1'b1, 16'd14400},
      '{32'h8000_0000,  1'b1, 17'd0, 1'b1, 16'd14400},
      '{32'h0100_0000,  1'b1, 17'd0, 1'b1, 16'd14400},
      '{32'd336,        1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd5033,       1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd33554,      1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd58720,      1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd120796,     1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd167772,     1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd301990,     1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd419430,     1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd838861,     1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd1677722,    1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd2348810,    1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd2348811,    1'b1, 17'd0, 1'b0, 16'd0},
      '{32'd100000,     1'b1, 17'd0, 1'b0, 16'd0}
   };

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_slope = '0;
      req_is_land = 1'b0;
      req_craton_weight = '0;
      csr_write_enable = 1'b0;
      csr_index = stv_pkg::CSR_WATER_VELOCITY;
      csr_write_data = '0;
      water_reg = 16'd9600;
      weight_sel_reg = 1'b0;
      fixed_weight_reg = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].known &&
             cell_vs30(directed[i].slope, directed[i].land, directed[i].weight)
             !== directed[i].vs30) begin
            $error("vs30: table row %0d expected %0d, predictor gives %0d", i,
                   directed[i].vs30,
                   cell_vs30(directed[i].slope, directed[i].land, directed[i].weight));
            errors++;
         end
         send_cell(directed[i].slope, directed[i].land, directed[i].weight, i % 3);
      end
      drain();

      random_cells(250, 1'b0);
      set_registers(17'h10000, 17'h1FFFE, 17'd65536);   // water 0, fixed full craton
      random_cells(250, 1'b1);
      set_registers(17'h1FFFF, 17'd1, 17'd0);           // water max, per-cell weight
      random_cells(280, 1'b0);
      set_registers(17'($urandom), 17'd0, 17'h1FFFF);   // fixed weight beyond full scale
      random_cells(250, 1'b0);
      set_registers(17'($urandom), 17'd0, 17'd32768);
      random_cells(250, 1'b1);
      set_registers(17'($urandom), 17'd1, 17'($urandom_range(65536)));
      random_cells(350, 1'b0);

      $display("Covered %0d cells (%0d land) and %0d results over %0d register settings.",
               accepted, land_cells, results_seen, settings_used);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timed out with %0d results outstanding.", vs30_expected.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
